[hw/rtl/dapg_pkg.sv]
// Shared types, constants and helper functions for the dream attractor point generator.
// Used by the controller, the datapath and the top level; depends on nothing else.
package dapg_pkg;

   localparam int SCREEN_WIDTH  = 1280;
   localparam int SCREEN_HEIGHT = 1024;
   localparam int PIXEL_SCALE   = 300;

   localparam int COORD_W  = 31;
   localparam int COEF_W   = 30;
   localparam int PIX_W    = 13;
   localparam int OP_W     = 34;
   localparam int PROD_W   = 2 * OP_W;
   localparam int SCALE_W  = $clog2(PIXEL_SCALE + 1) + 1;
   localparam int PPROD_W  = COORD_W + SCALE_W;
   localparam int PFLOOR_W = PPROD_W - 28;
   localparam int PSUM_W   = PFLOOR_W + 2;
   localparam int PIX_MAX  = (1 << (PIX_W - 1)) - 1;
   localparam int PIX_MIN  = -(1 << (PIX_W - 1));

   localparam logic [31:0] TURNS_PER_RAD = 32'd2734261102;
   localparam logic [32:0] HALF_PI       = 33'd6746518852;
   localparam logic [32:0] ONE_Q32       = 33'h1_0000_0000;

   localparam logic [2:0] CSR_COEF_A  = 3'd0;
   localparam logic [2:0] CSR_COEF_B  = 3'd1;
   localparam logic [2:0] CSR_COEF_C  = 3'd2;
   localparam logic [2:0] CSR_COEF_D  = 3'd3;
   localparam logic [2:0] CSR_START_X = 3'd4;
   localparam logic [2:0] CSR_START_Y = 3'd5;

   localparam logic [30:0] RESET_COEF_A  = 31'h50878101;
   localparam logic [30:0] RESET_COEF_B  = 31'h2E13FC01;
   localparam logic [29:0] RESET_COEF_C  = 30'h3A285DB7;
   localparam logic [29:0] RESET_COEF_D  = 30'h3A7BFE7E;
   localparam logic [30:0] RESET_START_X = 31'h7E666666;
   localparam logic [30:0] RESET_START_Y = 31'h00000000;

   // Sine evaluation order: x' uses sin(b*y) and sin(b*x), y' uses sin(a*x) and sin(a*y).
   localparam logic [1:0] SINE_BY = 2'd0;
   localparam logic [1:0] SINE_BX = 2'd1;
   localparam logic [1:0] SINE_AX = 2'd2;
   localparam logic [1:0] SINE_AY = 2'd3;

   localparam logic [3:0] FIRST_COS_TERM = 4'd4;
   localparam logic [3:0] LAST_SIN_TERM  = 4'd3;
   localparam logic [3:0] LAST_COS_TERM  = 4'd8;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_PQ, MUL_TPR, MUL_HPI, MUL_TT, MUL_ZH, MUL_RCP, MUL_THH, MUL_CS, MUL_DS
   } mul_op_type;

   typedef enum logic [3:0] {
      WB_NONE, WB_LOAD, WB_CAPTURE, WB_T, WB_PHASE, WB_TH, WB_Z, WB_DIV, WB_SIN, WB_SEL,
      WB_NX, WB_NY
   } wb_op_type;

   typedef struct packed {
      mul_op_type mul_op;
      wb_op_type  wb_op;
      logic [1:0] sine;
      logic [3:0] term;
   } dapg_cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_EMIT, ST_MUL_PQ, ST_WB_T, ST_MUL_TPR, ST_WB_PHASE, ST_MUL_HPI, ST_WB_TH,
      ST_MUL_TT, ST_WB_Z, ST_MUL_ZH, ST_MUL_RCP, ST_WB_DIV, ST_MUL_THH, ST_WB_SIN, ST_WB_SEL,
      ST_MUL_CS, ST_WB_NX, ST_MUL_DS, ST_WB_NY
   } state_type;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             visible;
   } pixel_type;

   // Divisors of the Taylor terms: four sine terms, then five cosine terms.
   function automatic logic [6:0] div_const(input logic [3:0] term);
      logic [6:0] d;
      case (term)
         4'd0: d = 7'd72;
         4'd1: d = 7'd42;
         4'd2: d = 7'd20;
         4'd3: d = 7'd6;
         4'd4: d = 7'd90;
         4'd5: d = 7'd56;
         4'd6: d = 7'd30;
         4'd7: d = 7'd12;
         4'd8: d = 7'd2;
         default: d = 7'd1;
      endcase
      return d;
   endfunction

   function automatic logic [5:0] div_shift(input logic [3:0] term);
      logic [5:0] k;
      case (term)
         4'd0: k = 6'd38;
         4'd1: k = 6'd37;
         4'd2: k = 6'd36;
         4'd3: k = 6'd34;
         4'd4: k = 6'd38;
         4'd5: k = 6'd37;
         4'd6: k = 6'd36;
         4'd7: k = 6'd35;
         4'd8: k = 6'd33;
         default: k = 6'd32;
      endcase
      return k;
   endfunction

   // Reciprocal floor(2^k / d); the quotient it gives is low by at most one.
   function automatic logic [32:0] div_recip(input logic [3:0] term);
      logic [32:0] m;
      case (term)
         4'd0: m = 33'd3817748707;
         4'd1: m = 33'd3272356035;
         4'd2: m = 33'd3435973836;
         4'd3: m = 33'd2863311530;
         4'd4: m = 33'd3054198966;
         4'd5: m = 33'd2454267026;
         4'd6: m = 33'd2290649224;
         4'd7: m = 33'd2863311530;
         4'd8: m = 33'd4294967296;
         default: m = 33'd4294967296;
      endcase
      return m;
   endfunction

   function automatic pixel_type pixel_map(input logic signed [COORD_W-1:0] v,
                                           input int half, input int span);
      logic signed [PPROD_W-1:0]  prod;
      logic signed [PSUM_W-1:0]   px;
      pixel_type                  res;
      prod = PPROD_W'(v) * PPROD_W'(signed'(SCALE_W'(PIXEL_SCALE)));
      px = PSUM_W'(signed'(prod[PPROD_W-1:28])) + PSUM_W'(half);
      res.visible = (px >= 0) && (px < PSUM_W'(span));
      if (px < PSUM_W'(PIX_MIN)) begin
         res.pix = PIX_W'(PIX_MIN);
      end else if (px > PSUM_W'(PIX_MAX)) begin
         res.pix = PIX_W'(PIX_MAX);
      end else begin
         res.pix = PIX_W'(px);
      end
      return res;
   endfunction

endpackage

[hw/rtl/dream_attractor_point_generator.sv]
// Dream attractor point generator: one orbit point and its pixel position per request word.
// Each request word is first answered with the current point, then the orbit advances
// through x' = sin(b*y) + c*sin(b*x), y' = sin(a*x) + d*sin(a*y), signed Q3.28 (c,d Q2.28).
// A request word with restart set reloads the start point before the answer is formed.
// The coefficient and start registers are written through the csr_ port at indexes 0..5
// (a, b, c, d, start x, start y); start values take effect at the next restart.
// The response word is captured in state ST_EMIT once no earlier word is left stalled, and is
// held in an output register until the receiver takes it; a stall on the response channel
// only delays the next answer, never the orbit update already under way.
// No new request word is taken until the last one's orbit update is done; the four sines
// run one after another through a single shared 34 x 34 multiplier (range reduction, then
// nine Taylor terms, each a product and a divide-by-constant), plus the two final products.
// Reset (synchronous, active high) loads the default coefficients and start point and
// places the orbit at the start point; no response word is pending after reset.
module dream_attractor_point_generator import dapg_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_restart,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic signed [PIX_W-1:0]   rsp_pixel_col,
   output logic signed [PIX_W-1:0]   rsp_pixel_row,
   output logic                      rsp_on_screen,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [COORD_W-1:0]        csr_wdata
);

   dapg_cmd_type cmd;

   dapg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   dapg_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_restart   (req_restart),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_pixel_col (rsp_pixel_col),
      .rsp_pixel_row (rsp_pixel_row),
      .rsp_on_screen (rsp_on_screen)
   );

endmodule

[hw/rtl/dapg_ctrl.sv]
// Sequencer of the dream attractor point generator: handshakes and multiply/write-back steps.
// Depends on dapg_pkg for the state, command and term constants.
module dapg_ctrl import dapg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output dapg_cmd_type cmd
);

   state_type  state_ff, state_in;
   logic [3:0] term_ff, term_in;
   logic [1:0] sine_ff, sine_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= '0;
         sine_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         sine_ff      <= sine_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      sine_in      = sine_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      cmd.mul_op   = MUL_NONE;
      cmd.wb_op    = WB_NONE;
      cmd.sine     = sine_ff;
      cmd.term     = term_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.wb_op = WB_LOAD;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.wb_op    = WB_CAPTURE;
               rsp_valid_in = 1'b1;
               sine_in      = SINE_BY;
               state_in     = ST_MUL_PQ;
            end
         end
         ST_MUL_PQ: begin
            cmd.mul_op = MUL_PQ;
            state_in   = ST_WB_T;
         end
         ST_WB_T: begin
            cmd.wb_op = WB_T;
            state_in  = ST_MUL_TPR;
         end
         ST_MUL_TPR: begin
            cmd.mul_op = MUL_TPR;
            state_in   = ST_WB_PHASE;
         end
         ST_WB_PHASE: begin
            cmd.wb_op = WB_PHASE;
            state_in  = ST_MUL_HPI;
         end
         ST_MUL_HPI: begin
            cmd.mul_op = MUL_HPI;
            state_in   = ST_WB_TH;
         end
         ST_WB_TH: begin
            cmd.wb_op = WB_TH;
            state_in  = ST_MUL_TT;
         end
         ST_MUL_TT: begin
            cmd.mul_op = MUL_TT;
            state_in   = ST_WB_Z;
         end
         ST_WB_Z: begin
            cmd.wb_op = WB_Z;
            term_in   = '0;
            state_in  = ST_MUL_ZH;
         end
         ST_MUL_ZH: begin
            cmd.mul_op = MUL_ZH;
            state_in   = ST_MUL_RCP;
         end
         ST_MUL_RCP: begin
            cmd.mul_op = MUL_RCP;
            state_in   = ST_WB_DIV;
         end
         ST_WB_DIV: begin
            cmd.wb_op = WB_DIV;
            if (term_ff == LAST_SIN_TERM) begin
               state_in = ST_MUL_THH;
            end else if (term_ff == LAST_COS_TERM) begin
               state_in = ST_WB_SEL;
            end else begin
               term_in  = term_ff + 4'd1;
               state_in = ST_MUL_ZH;
            end
         end
         ST_MUL_THH: begin
            cmd.mul_op = MUL_THH;
            state_in   = ST_WB_SIN;
         end
         ST_WB_SIN: begin
            cmd.wb_op = WB_SIN;
            term_in   = FIRST_COS_TERM;
            state_in  = ST_MUL_ZH;
         end
         ST_WB_SEL: begin
            cmd.wb_op = WB_SEL;
            if (sine_ff == SINE_AY) begin
               state_in = ST_MUL_CS;
            end else begin
               sine_in  = sine_ff + 2'd1;
               state_in = ST_MUL_PQ;
            end
         end
         ST_MUL_CS: begin
            cmd.mul_op = MUL_CS;
            state_in   = ST_WB_NX;
         end
         ST_WB_NX: begin
            cmd.wb_op = WB_NX;
            state_in  = ST_MUL_DS;
         end
         ST_MUL_DS: begin
            cmd.mul_op = MUL_DS;
            state_in   = ST_WB_NY;
         end
         ST_WB_NY: begin
            cmd.wb_op = WB_NY;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/dapg_datapath.sv]
// Datapath of the dream attractor point generator: registers, shared multiplier, sine steps.
// Depends on dapg_pkg; driven by the command word from dapg_ctrl.
module dapg_datapath import dapg_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  dapg_cmd_type              cmd,
   input  logic                      req_restart,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [COORD_W-1:0]        csr_wdata,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic signed [PIX_W-1:0]   rsp_pixel_col,
   output logic signed [PIX_W-1:0]   rsp_pixel_row,
   output logic                      rsp_on_screen
);

   logic signed [COORD_W-1:0] coef_a_ff, coef_b_ff, start_x_ff, start_y_ff;
   logic signed [COEF_W-1:0]  coef_c_ff, coef_d_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [OP_W-1:0]    op_a, op_b;
   logic [32:0]               mag_ff;
   logic                      neg_ff, swap_ff;
   logic [1:0]                quad_ff;
   logic [29:0]               uf_ff;
   logic [31:0]               th_ff, z_ff, m_ff, sin_ff;
   logic [32:0]               h_ff;
   logic signed [29:0]        sres_ff [4];

   logic [PROD_W-1:0]         prod_u, rnd_sum;
   logic signed [33:0]        t_val;
   logic [32:0]               mag_val;
   logic [31:0]               phase;
   logic [31:0]               q0;
   logic [38:0]               rem;
   logic [31:0]               quo;
   logic [32:0]               v_sel;
   logic [33:0]               v_rnd;
   logic [29:0]               v_mag;
   logic signed [COORD_W-1:0] prod_q28;
   logic signed [COORD_W:0]   next_x, next_y;
   pixel_type                 px_col, px_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff  <= RESET_COEF_A;
         coef_b_ff  <= RESET_COEF_B;
         coef_c_ff  <= RESET_COEF_C;
         coef_d_ff  <= RESET_COEF_D;
         start_x_ff <= RESET_START_X;
         start_y_ff <= RESET_START_Y;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COEF_A:  coef_a_ff  <= csr_wdata;
            CSR_COEF_B:  coef_b_ff  <= csr_wdata;
            CSR_COEF_C:  coef_c_ff  <= csr_wdata[COEF_W-1:0];
            CSR_COEF_D:  coef_d_ff  <= csr_wdata[COEF_W-1:0];
            CSR_START_X: start_x_ff <= csr_wdata;
            CSR_START_Y: start_y_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.mul_op)
         MUL_PQ: begin
            case (cmd.sine)
               SINE_BY: begin
                  op_a = OP_W'(coef_b_ff);
                  op_b = OP_W'(y_ff);
               end
               SINE_BX: begin
                  op_a = OP_W'(coef_b_ff);
                  op_b = OP_W'(x_ff);
               end
               SINE_AX: begin
                  op_a = OP_W'(coef_a_ff);
                  op_b = OP_W'(x_ff);
               end
               default: begin
                  op_a = OP_W'(coef_a_ff);
                  op_b = OP_W'(y_ff);
               end
            endcase
         end
         MUL_TPR: begin
            op_a = {1'b0, mag_ff};
            op_b = {2'b00, TURNS_PER_RAD};
         end
         MUL_HPI: begin
            op_a = {4'b0000, uf_ff};
            op_b = {1'b0, HALF_PI};
         end
         MUL_TT: begin
            op_a = {2'b00, th_ff};
            op_b = {2'b00, th_ff};
         end
         MUL_ZH: begin
            op_a = {2'b00, z_ff};
            op_b = {1'b0, h_ff};
         end
         MUL_RCP: begin
            op_a = {2'b00, prod_u[63:32]};
            op_b = {1'b0, div_recip(cmd.term)};
         end
         MUL_THH: begin
            op_a = {2'b00, th_ff};
            op_b = {1'b0, h_ff};
         end
         MUL_CS: begin
            op_a = OP_W'(coef_c_ff);
            op_b = OP_W'(sres_ff[SINE_BX]);
         end
         MUL_DS: begin
            op_a = OP_W'(coef_d_ff);
            op_b = OP_W'(sres_ff[SINE_AY]);
         end
         default: begin
         end
      endcase
   end

   assign prod_in = op_a * op_b;
   assign prod_u  = prod_ff;
   assign rnd_sum = prod_u + PROD_W'(1 << 27);

   always_comb begin
      t_val    = signed'(rnd_sum[61:28]);
      mag_val  = t_val[33] ? 33'(-t_val) : 33'(t_val);
      phase    = neg_ff ? (32'd0 - prod_u[61:30]) : prod_u[61:30];
      q0       = 32'(prod_u >> div_shift(cmd.term));
      rem      = {7'd0, m_ff} - (39'(q0) * 39'(div_const(cmd.term)));
      quo      = (rem >= 39'(div_const(cmd.term))) ? q0 + 32'd1 : q0;
      v_sel    = (quad_ff[0] ^ swap_ff) ? h_ff : {1'b0, sin_ff};
      v_rnd    = 34'(v_sel) + 34'd8;
      v_mag    = v_rnd[33:4];
      prod_q28 = signed'(rnd_sum[58:28]);
      next_x   = (COORD_W+1)'(sres_ff[SINE_BY]) + (COORD_W+1)'(prod_q28);
      next_y   = (COORD_W+1)'(sres_ff[SINE_AX]) + (COORD_W+1)'(prod_q28);
      px_col   = pixel_map(x_ff, SCREEN_WIDTH / 2, SCREEN_WIDTH);
      px_row   = pixel_map(y_ff, SCREEN_HEIGHT / 2, SCREEN_HEIGHT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= RESET_START_X;
         y_ff <= RESET_START_Y;
      end else begin
         case (cmd.wb_op)
            WB_LOAD: begin
               if (req_restart) begin
                  x_ff <= start_x_ff;
                  y_ff <= start_y_ff;
               end
            end
            WB_NX: x_ff <= next_x[COORD_W-1:0];
            WB_NY: y_ff <= next_y[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_op != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (cmd.mul_op == MUL_RCP) begin
         m_ff <= prod_u[63:32];
      end
      case (cmd.wb_op)
         WB_CAPTURE: begin
            rsp_point_x   <= x_ff;
            rsp_point_y   <= y_ff;
            rsp_pixel_col <= px_col.pix;
            rsp_pixel_row <= px_row.pix;
            rsp_on_screen <= px_col.visible && px_row.visible;
         end
         WB_T: begin
            neg_ff <= t_val[33];
            mag_ff <= mag_val;
         end
         WB_PHASE: begin
            quad_ff <= phase[31:30];
            swap_ff <= phase[29];
            uf_ff   <= phase[29] ? 30'(31'h4000_0000 - {1'b0, phase[29:0]}) : phase[29:0];
         end
         WB_TH: th_ff <= prod_u[61:30];
         WB_Z: begin
            z_ff <= prod_u[63:32];
            h_ff <= ONE_Q32;
         end
         WB_DIV: h_ff <= ONE_Q32 - {1'b0, quo};
         WB_SIN: begin
            sin_ff <= prod_u[63:32];
            h_ff   <= ONE_Q32;
         end
         WB_SEL: sres_ff[cmd.sine] <= quad_ff[1] ? -signed'(v_mag) : signed'(v_mag);
         default: begin
         end
      endcase
   end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the dream attractor point generator.
// Drives request words and coefficient settings, predicts every orbit point in fixed point.
// Depends on dapg_pkg and dream_attractor_point_generator only.
`timescale 1ns / 100ps

module tb_top;
   import dapg_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [PIX_W-1:0]   col;
      logic [PIX_W-1:0]   row;
      logic               on;
   } point_type;

   typedef struct packed {
      logic      restart;
      logic      typed;
      point_type pt;
   } dir_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_restart = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [COORD_W-1:0] rsp_point_x;
   logic signed [COORD_W-1:0] rsp_point_y;
   logic signed [PIX_W-1:0]   rsp_pixel_col;
   logic signed [PIX_W-1:0]   rsp_pixel_row;
   logic                      rsp_on_screen;
   logic                      csr_we = 1'b0;
   logic [2:0]                csr_index = '0;
   logic [COORD_W-1:0]        csr_wdata = '0;

   longint    m_a, m_b, m_c, m_d, m_sx, m_sy, orbit_x, orbit_y;
   point_type point_q[$];
   int        mismatches = 0;
   int        gap_pct = 0;
   int        stall_pct = 0;

   always #4 clock = ~clock;

   dream_attractor_point_generator dut (.*);

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   function automatic longint unsigned mq32(longint unsigned a, longint unsigned b);
      return (a * b) >> 32;
   endfunction

   function automatic longint unsigned taylor_sin(longint unsigned th);
      longint unsigned z, h;
      z = mq32(th, th);
      h = 64'h1_0000_0000;
      h = 64'h1_0000_0000 - mq32(z, h) / 72;
      h = 64'h1_0000_0000 - mq32(z, h) / 42;
      h = 64'h1_0000_0000 - mq32(z, h) / 20;
      h = 64'h1_0000_0000 - mq32(z, h) / 6;
      return mq32(th, h);
   endfunction

   function automatic longint unsigned taylor_cos(longint unsigned th);
      longint unsigned z, h;
      z = mq32(th, th);
      h = 64'h1_0000_0000;
      h = 64'h1_0000_0000 - mq32(z, h) / 90;
      h = 64'h1_0000_0000 - mq32(z, h) / 56;
      h = 64'h1_0000_0000 - mq32(z, h) / 30;
      h = 64'h1_0000_0000 - mq32(z, h) / 12;
      h = 64'h1_0000_0000 - mq32(z, h) / 2;
      return h;
   endfunction

   function automatic longint sine_q28(longint p, longint q);
      longint          t;
      longint unsigned mag, th, sp, cp, v;
      logic [31:0]     phase;
      logic [29:0]     u;
      t = (p * q + 64'sd134217728) >>> 28;
      mag = (t < 0) ? -t : t;
      phase = 32'((mag * 64'd2734261102) >> 30);
      if (t < 0) phase = -phase;
      u = phase[29:0];
      if (u < 30'h2000_0000) begin
         th = (64'(u) * 64'd6746518852) >> 30;
         sp = taylor_sin(th);
         cp = taylor_cos(th);
      end else begin
         th = ((64'h4000_0000 - 64'(u)) * 64'd6746518852) >> 30;
         sp = taylor_cos(th);
         cp = taylor_sin(th);
      end
      v = phase[30] ? cp : sp;
      v = (v + 8) >> 4;
      return phase[31] ? -longint'(v) : longint'(v);
   endfunction

   function automatic longint round_q28(longint a, longint b);
      return (a * b + 64'sd134217728) >>> 28;
   endfunction

   function automatic logic [PIX_W-1:0] screen_pos(longint v, longint half, longint span,
                                                   inout logic on);
      longint px;
      px = ((v * PIXEL_SCALE) >>> 28) + half;
      if (px < 0 || px >= span) on = 1'b0;
      if (px < PIX_MIN) px = PIX_MIN;
      if (px > PIX_MAX) px = PIX_MAX;
      return PIX_W'(px);
   endfunction

   function automatic point_type next_point(logic restart);
      point_type pt;
      longint    nx, ny;
      logic      on;
      on = 1'b1;
      if (restart) begin
         orbit_x = m_sx;
         orbit_y = m_sy;
      end
      pt.x = COORD_W'(orbit_x);
      pt.y = COORD_W'(orbit_y);
      pt.col = screen_pos(orbit_x, SCREEN_WIDTH / 2, SCREEN_WIDTH, on);
      pt.row = screen_pos(orbit_y, SCREEN_HEIGHT / 2, SCREEN_HEIGHT, on);
      pt.on = on;
      nx = sine_q28(m_b, orbit_y) + round_q28(m_c, sine_q28(m_b, orbit_x));
      ny = sine_q28(m_a, orbit_x) + round_q28(m_d, sine_q28(m_a, orbit_y));
      orbit_x = longint'(signed'(COORD_W'(nx)));
      orbit_y = longint'(signed'(COORD_W'(ny)));
      return pt;
   endfunction

   always @(posedge clock) begin
      point_type got, want;
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_point_x, rsp_point_y, rsp_pixel_col, rsp_pixel_row, rsp_on_screen};
         if (point_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
         end else begin
            want = point_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch x %h/%h y %h/%h col %h/%h row %h/%h on %b/%b",
                           want.x, got.x, want.y, got.y, want.col, got.col,
                           want.row, got.row, want.on, got.on);
            end
         end
      end
   end

   task automatic send_word(logic restart, logic typed, point_type pt);
      point_type p;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      p = next_point(restart);
      point_q.push_back(typed ? pt : p);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (point_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [COORD_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_COEF_A:  m_a = longint'(signed'(data));
         CSR_COEF_B:  m_b = longint'(signed'(data));
         CSR_COEF_C:  m_c = longint'(signed'(data[COEF_W-1:0]));
         CSR_COEF_D:  m_d = longint'(signed'(data[COEF_W-1:0]));
         CSR_START_X: m_sx = longint'(signed'(data));
         CSR_START_Y: m_sy = longint'(signed'(data));
         default: ;
      endcase
   endtask

   function automatic logic [COORD_W-1:0] pick(int lim, int phase);
      if (phase == 1) return COORD_W'(lim);
      if (phase == 2) return COORD_W'(-lim);
      if (phase == 3) return 31'h3FFF_FFFF;
      if (phase == 4) return 31'h4000_0000;
      if (phase % 3 == 0) return COORD_W'($urandom);
      return COORD_W'(int'($urandom_range(2 * lim)) - lim);
   endfunction

   dir_row_type dir_rows[$] = '{
      '{1'b1, 1'b1, '{31'h7E666666, 31'h0, 13'd609, 13'd512, 1'b1}},
      '{1'b0, 1'b0, '0}, '{1'b0, 1'b0, '0}, '{1'b0, 1'b0, '0},
      '{1'b1, 1'b1, '{31'h7E666666, 31'h0, 13'd609, 13'd512, 1'b1}},
      '{1'b0, 1'b0, '0}, '{1'b1, 1'b0, '0}, '{1'b0, 1'b0, '0}
   };

   initial begin
      point_type none;
      none = '0;
      m_a = -796425983;
      m_b = 773061633;
      m_c = -98017865;
      m_d = -92537218;
      m_sx = -26843546;
      m_sy = 0;
      orbit_x = m_sx;
      orbit_y = m_sy;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) send_word(dir_rows[i].restart, dir_rows[i].typed, dir_rows[i].pt);
      drain();
      // Start registers written here must not move the orbit until the next restart.
      write_reg(CSR_START_X, 31'h2000_0000);
      write_reg(CSR_START_Y, 31'h6000_0000);
      repeat (3) send_word(1'b0, 1'b0, none);
      send_word(1'b1, 1'b0, none);
      send_word(1'b0, 1'b0, none);
      drain();
      for (int phase = 1; phase <= 8; phase++) begin
         write_reg(CSR_COEF_A, pick(805306368, phase));
         write_reg(CSR_COEF_B, pick(805306368, phase));
         write_reg(CSR_COEF_C, pick(268435456, phase));
         write_reg(CSR_COEF_D, pick(268435456, phase));
         write_reg(CSR_START_X, pick(536870912, phase));
         write_reg(CSR_START_Y, pick(536870912, 9 - phase));
         write_reg(3'd6, COORD_W'($urandom));
         write_reg(3'd7, COORD_W'($urandom));
         case (phase % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 50; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 50; end
            default: begin gap_pct = 31; stall_pct = 31; end
         endcase
         for (int n = 0; n < 235; n++) begin
            if (n == 120) begin
               req_valid <= 1'b0;
               while (point_q.size() != 0) @(posedge clock);
            end
            send_word(n == 0 || $urandom_range(19) == 0, 1'b0, none);
         end
         gap_pct = 0;
         stall_pct = 0;
         drain();
      end
      if (mismatches == 0 && point_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/dapg_pkg.sv
hw/rtl/dapg_ctrl.sv
hw/rtl/dapg_datapath.sv
hw/rtl/dream_attractor_point_generator.sv
tb/tb_top.sv
